// ===== sv/pnce_pkg.sv =====
package pnce_pkg;

	localparam int PIX_W      = 24;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int NUM_NBR    = 8;
	localparam int SQ_W       = 2 * CH_W;
	localparam int WGT_W      = 11;
	localparam int PROD_W     = SQ_W + WGT_W;
	localparam int COST_W     = 28;
	localparam int PAIR_W     = COST_W + 1;
	localparam int TOTAL_W    = COST_W + 3;
	localparam int CNT_W      = 4;
	localparam int ENERGY_W   = 28;
	localparam int COORD_W    = 12;
	localparam int REG_W      = 13;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEP   = 8;
	localparam int DVD_W      = DIV_STAGES * DIV_STEP;
	localparam int REM_W      = 3;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = 28'd199756800;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_DIRECTIONS = 8'd3;

	localparam logic [MODE_W-1:0] MODE_EQUAL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LUMA_A = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LUMA_B = 2'd2;

	typedef struct packed {
		logic s1;
		logic s2;
	} lane_en_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} merge_en_t;

	typedef logic [DIV_STAGES-1:0] div_en_t;

	function automatic logic [WGT_W-1:0] weight_q10(input logic [MODE_W-1:0] mode,
		input int ch);
		logic [WGT_W-1:0] w;
		w = '0;
		case (mode)
			MODE_EQUAL: begin
				w = 11'd1024;
			end
			MODE_LUMA_A: begin
				w = (ch == 0) ? 11'd164 : (ch == 1) ? 11'd532 : 11'd328;
			end
			MODE_LUMA_B: begin
				w = (ch == 0) ? 11'd117 : (ch == 1) ? 11'd601 : 11'd306;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/pixel_neighbor_color_energy_unit.sv =====
// path: accepted input word -> lane s1, s2 -> merge s3, s4 -> divider stages -> result word at the output
// throughput: one word per cycle while out_stall is low, set by the lane multipliers and the 4-stage divider
// each stage advances when empty or when the stage after it moves, so under stall input is taken
// only while some stage of the pipeline still holds no word
// reset: pipeline valid flags clear, width and height 1, color_mode 0, all_directions 0
module pixel_neighbor_color_energy_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pnce_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pnce_pkg::REG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pnce_pkg::COORD_W-1:0]          col,
	input  logic [pnce_pkg::COORD_W-1:0]          row,
	input  logic [pnce_pkg::PIX_W-1:0]            center_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            up_left_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            up_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            up_right_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            left_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            right_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            down_left_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            down_pixel,
	input  logic [pnce_pkg::PIX_W-1:0]            down_right_pixel,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pnce_pkg::ENERGY_W-1:0]         energy,
	output logic [pnce_pkg::CNT_W-1:0]            neighbor_count
);
	import pnce_pkg::*;

	localparam int DIM_BITS = $clog2(MAX_DIM + 1);
	localparam int CMP_W    = (DIM_BITS > REG_W + 1) ? DIM_BITS : REG_W + 1;
	localparam logic [CMP_W-1:0] MAX_V = CMP_W'(MAX_DIM);
	localparam int NSTG     = 4 + DIV_STAGES;

	logic [REG_W-1:0]  width_q;
	logic [REG_W-1:0]  height_q;
	logic [MODE_W-1:0] mode_q;
	logic              all_dir_q;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] rdy;

	logic [CMP_W-1:0]   w_eff;
	logic [CMP_W-1:0]   h_eff;
	logic [CMP_W-1:0]   xe;
	logic [CMP_W-1:0]   ye;
	logic [2:0]         colv;
	logic [2:0]         rowv;
	logic [NUM_NBR-1:0] mask;
	logic [NUM_NBR-1:0] mask_s1;
	logic [CNT_W-1:0]   cnt_s1;
	logic [CNT_W-1:0]   cnt_s2;
	logic [CNT_W-1:0]   cnt_s3;
	logic [CNT_W-1:0]   cnt_s4;

	logic [PIX_W-1:0]  nbr  [NUM_NBR];
	logic [COST_W-1:0] cost [NUM_NBR];
	logic [TOTAL_W-1:0] total;

	lane_en_t  lane_en;
	merge_en_t merge_en;
	div_en_t   div_en;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= REG_W'(1);
			height_q  <= REG_W'(1);
			mode_q    <= MODE_EQUAL;
			all_dir_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:    width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:   height_q  <= cfg_data;
				REG_COLOR_MODE:     mode_q    <= cfg_data[MODE_W-1:0];
				REG_ALL_DIRECTIONS: all_dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	always_comb begin
		rdy[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall = !rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// neighbor bounds
	always_comb begin
		w_eff = (CMP_W'(width_q) > MAX_V) ? MAX_V : CMP_W'(width_q);
		h_eff = (CMP_W'(height_q) > MAX_V) ? MAX_V : CMP_W'(height_q);
		xe    = CMP_W'(col);
		ye    = CMP_W'(row);
		colv[0] = (col != '0) && (xe <= w_eff);
		colv[1] = xe < w_eff;
		colv[2] = (xe + CMP_W'(1)) < w_eff;
		rowv[0] = (row != '0) && (ye <= h_eff);
		rowv[1] = ye < h_eff;
		rowv[2] = (ye + CMP_W'(1)) < h_eff;
		mask[0] = colv[0] && rowv[0] && all_dir_q;
		mask[1] = colv[1] && rowv[0];
		mask[2] = colv[2] && rowv[0] && all_dir_q;
		mask[3] = colv[0] && rowv[1];
		mask[4] = colv[2] && rowv[1];
		mask[5] = colv[0] && rowv[2] && all_dir_q;
		mask[6] = colv[1] && rowv[2];
		mask[7] = colv[2] && rowv[2] && all_dir_q;
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			mask_s1 <= mask;
			cnt_s1  <= CNT_W'($countones(mask));
		end
		if (rdy[2]) begin
			cnt_s2 <= cnt_s1;
		end
		if (rdy[3]) begin
			cnt_s3 <= cnt_s2;
		end
		if (rdy[4]) begin
			cnt_s4 <= cnt_s3;
		end
	end

	// lanes
	always_comb begin
		nbr[0] = up_left_pixel;
		nbr[1] = up_pixel;
		nbr[2] = up_right_pixel;
		nbr[3] = left_pixel;
		nbr[4] = right_pixel;
		nbr[5] = down_left_pixel;
		nbr[6] = down_pixel;
		nbr[7] = down_right_pixel;
		lane_en.s1  = rdy[1];
		lane_en.s2  = rdy[2];
		merge_en.s3 = rdy[3];
		merge_en.s4 = rdy[4];
		div_en      = rdy[NSTG:5];
	end

	for (genvar k = 0; k < NUM_NBR; k++) begin : g_lane
		pnce_lane u_lane (
			.clk        (clk),
			.en         (lane_en),
			.color_mode (mode_q),
			.center     (center_pixel),
			.nbr        (nbr[k]),
			.nbr_ok     (mask_s1[k]),
			.cost       (cost[k])
		);
	end

	pnce_merge u_merge (
		.clk   (clk),
		.en    (merge_en),
		.cost  (cost),
		.total (total)
	);

	pnce_div u_div (
		.clk    (clk),
		.en     (div_en),
		.total  (total),
		.cnt    (cnt_s4),
		.energy (energy),
		.count  (neighbor_count)
	);

	assign out_valid = vld_q[NSTG];

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && neighbor_count == '0 |-> energy == '0)
		else $error("energy nonzero with no neighbor");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> neighbor_count <= (all_dir_q ? CNT_W'(8) : CNT_W'(4)))
		else $error("neighbor count above limit");

	a_energy_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> energy <= ENERGY_MAX)
		else $error("energy out of range");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[1])
		else $error("accepted word lost at first stage");

endmodule

// ===== sv/pnce_lane.sv =====
module pnce_lane (
	input  logic                                 clk,
	input  pnce_pkg::lane_en_t                   en,
	input  logic [pnce_pkg::MODE_W-1:0]          color_mode,
	input  logic [pnce_pkg::PIX_W-1:0]           center,
	input  logic [pnce_pkg::PIX_W-1:0]           nbr,
	input  logic                                 nbr_ok,
	output logic [pnce_pkg::COST_W-1:0]          cost
);
	import pnce_pkg::*;

	logic [SQ_W-1:0]   sq_d  [NUM_CH];
	logic [SQ_W-1:0]   sq_s1 [NUM_CH];
	logic [PROD_W-1:0] prod  [NUM_CH];
	logic [COST_W-1:0] cost_s2;

	// absolute channel difference, squared
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			logic [CH_W-1:0] a;
			logic [CH_W-1:0] b;
			logic [CH_W-1:0] d;
			a = center[ch*CH_W +: CH_W];
			b = nbr[ch*CH_W +: CH_W];
			d = (a >= b) ? a - b : b - a;
			sq_d[ch] = SQ_W'(d) * SQ_W'(d);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				sq_s1[ch] <= sq_d[ch];
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod[ch] = PROD_W'(sq_s1[ch]) * PROD_W'(weight_q10(color_mode, ch));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cost_s2 <= nbr_ok ? COST_W'(prod[0]) + COST_W'(prod[1]) + COST_W'(prod[2]) : '0;
		end
	end

	assign cost = cost_s2;

endmodule

// ===== sv/pnce_merge.sv =====
module pnce_merge (
	input  logic                          clk,
	input  pnce_pkg::merge_en_t           en,
	input  logic [pnce_pkg::COST_W-1:0]   cost [pnce_pkg::NUM_NBR],
	output logic [pnce_pkg::TOTAL_W-1:0]  total
);
	import pnce_pkg::*;

	logic [PAIR_W-1:0]  pair_s3 [NUM_NBR/2];
	logic [TOTAL_W-1:0] total_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < NUM_NBR/2; i++) begin
				pair_s3[i] <= PAIR_W'(cost[2*i]) + PAIR_W'(cost[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			total_s4 <= TOTAL_W'(pair_s3[0]) + TOTAL_W'(pair_s3[1])
				+ TOTAL_W'(pair_s3[2]) + TOTAL_W'(pair_s3[3]);
		end
	end

	assign total = total_s4;

endmodule

// ===== sv/pnce_div.sv =====
module pnce_div (
	input  logic                           clk,
	input  pnce_pkg::div_en_t              en,
	input  logic [pnce_pkg::TOTAL_W-1:0]   total,
	input  logic [pnce_pkg::CNT_W-1:0]     cnt,
	output logic [pnce_pkg::ENERGY_W-1:0]  energy,
	output logic [pnce_pkg::CNT_W-1:0]     count
);
	import pnce_pkg::*;

	typedef struct packed {
		logic [DVD_W-1:0] num;
		logic [REM_W-1:0] rem;
	} div_st_t;

	// restoring division, one quotient bit per step
	function automatic div_st_t div_steps(input div_st_t s, input logic [CNT_W-1:0] d);
		div_st_t          r;
		logic [CNT_W-1:0] part;
		logic             qb;
		r = s;
		for (int i = 0; i < DIV_STEP; i++) begin
			part  = {r.rem, r.num[DVD_W-1]};
			qb    = (part >= d);
			r.num = {r.num[DVD_W-2:0], qb};
			r.rem = qb ? REM_W'(part - d) : REM_W'(part);
		end
		return r;
	endfunction

	div_st_t          st_s  [DIV_STAGES];
	logic [CNT_W-1:0] dsr_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		div_st_t          st_in;
		logic [CNT_W-1:0] dsr_in;

		if (j == 0) begin : g_first
			always_comb begin
				st_in.num = DVD_W'(total);
				st_in.rem = '0;
				dsr_in    = cnt;
			end
		end else begin : g_next
			always_comb begin
				st_in  = st_s[j-1];
				dsr_in = dsr_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				st_s[j]  <= div_steps(st_in, dsr_in);
				dsr_s[j] <= dsr_in;
			end
		end
	end

	// no valid neighbor gives zero
	assign energy = (dsr_s[DIV_STAGES-1] == '0) ? '0
		: st_s[DIV_STAGES-1].num[ENERGY_W-1:0];
	assign count  = dsr_s[DIV_STAGES-1];

endmodule
